// ----- hw/rtl/trqp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trqp_pkg
// Shared types for the priority ready queue: operation codes, the request
// and result payloads, and the stored slot entry.
// ----------------------------------------------------------------------------
package trqp_pkg;

  typedef enum logic [1:0] {
    OP_FIFO_ENQ = 2'd0,
    OP_PRIO_ENQ = 2'd1,
    OP_DEQUEUE  = 2'd2,
    OP_PEEK     = 2'd3
  } trqp_op_e;

  typedef struct packed {
    trqp_op_e   op;
    logic [7:0] task_id;
    logic [7:0] priority_req;
  } trqp_req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] task_out;
    logic [7:0] priority_out;
    logic       dropped;
    logic       queue_empty;
  } trqp_res_t;

  typedef struct packed {
    logic [7:0] task_id;
    logic [7:0] prio;
  } trqp_entry_t;

endpackage

// ----- hw/rtl/task_ready_queue_priority.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_ready_queue_priority
// Bounded ready queue of task entries kept as a ring in slot memory, with
// FIFO enqueue, priority insert behind the head, dequeue and peek.
// ----------------------------------------------------------------------------
// FIFO enqueue, dropped enqueue and empty dequeue/peek: result in the cycle after
//   the transfer, busy stays low, so one of these can be taken every cycle.
// Dequeue/peek on a non-empty queue: busy while in the head state.
// Priority enqueue with n >= 2 entries: busy through the scan and tail states;
//   the walk reads one slot per cycle from the single read port.
// Reset clears the entry count and head pointer; slot memory is not cleared.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
module task_ready_queue_priority #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  trqp_pkg::trqp_req_t req_i,
  output logic                done_o,
  output trqp_pkg::trqp_res_t res_o
);
  import trqp_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;
  localparam logic [1:0] ST_HEAD = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             ins_q, ins_d;
  logic             deq_q, deq_d;
  trqp_entry_t      carry_q, carry_d;
  logic             done_q, done_d;
  trqp_res_t        res_q, res_d;

  logic             accept;
  logic             full;
  logic             hit;
  trqp_entry_t      new_entry;
  trqp_entry_t      rd_entry;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  trqp_entry_t      ram_wdata;

  // Map a queue position to its slot in the ring.
  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign accept    = start && !busy;
  assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
  assign new_entry = '{task_id: req_i.task_id, prio: req_i.priority_req};
  assign hit       = !ins_q && (carry_q.prio > rd_entry.prio);

  trqp_slot_ram #(
    .Depth (QUEUE_DEPTH),
    .AddrW (IDX_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    head_d    = head_q;
    idx_d     = idx_q;
    ins_d     = ins_q;
    deq_d     = deq_q;
    carry_d   = carry_q;
    done_d    = 1'b0;
    res_d     = '0;
    ram_we    = 1'b0;
    ram_waddr = slot_addr(head_q, count_q[IDX_W-1:0]);
    ram_wdata = carry_q;
    ram_raddr = head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.op)
            OP_FIFO_ENQ, OP_PRIO_ENQ: begin
              if (full) begin
                done_d            = 1'b1;
                res_d.dropped     = 1'b1;
                res_d.queue_empty = 1'b0;
              end else if (req_i.op == OP_PRIO_ENQ && count_q >= CNT_W'(2)) begin
                // walk from the entry behind the head
                state_d   = ST_SCAN;
                idx_d     = IDX_W'(1);
                ins_d     = 1'b0;
                carry_d   = new_entry;
                ram_raddr = slot_addr(head_q, IDX_W'(1));
              end else begin
                ram_we            = 1'b1;
                ram_wdata         = new_entry;
                count_d           = count_q + CNT_W'(1);
                done_d            = 1'b1;
                res_d.queue_empty = 1'b0;
              end
            end
            OP_DEQUEUE, OP_PEEK: begin
              if (count_q == '0) begin
                done_d            = 1'b1;
                res_d.queue_empty = 1'b1;
              end else begin
                state_d   = ST_HEAD;
                deq_d     = (req_i.op == OP_DEQUEUE);
                ram_raddr = head_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // once the insert point is passed, ripple each entry one place back
        ram_we    = ins_q || hit;
        ram_waddr = slot_addr(head_q, idx_q);
        ram_wdata = carry_q;
        carry_d   = (ins_q || hit) ? rd_entry : carry_q;
        ins_d     = ins_q || hit;
        if (CNT_W'(idx_q) + CNT_W'(1) == count_q) begin
          state_d = ST_TAIL;
        end else begin
          idx_d     = idx_q + IDX_W'(1);
          ram_raddr = slot_addr(head_q, idx_q + IDX_W'(1));
        end
      end
      ST_TAIL: begin
        ram_we            = 1'b1;
        ram_wdata         = carry_q;
        count_d           = count_q + CNT_W'(1);
        done_d            = 1'b1;
        res_d.queue_empty = 1'b0;
        state_d           = ST_IDLE;
      end
      ST_HEAD: begin
        done_d             = 1'b1;
        res_d.found        = 1'b1;
        res_d.task_out     = rd_entry.task_id;
        res_d.priority_out = rd_entry.prio;
        if (deq_q) begin
          head_d            = slot_addr(head_q, IDX_W'(1));
          count_d           = count_q - CNT_W'(1);
          res_d.queue_empty = (count_q == CNT_W'(1));
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      head_q  <= '0;
      idx_q   <= '0;
      ins_q   <= 1'b0;
      deq_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
      idx_q   <= idx_d;
      ins_q   <= ins_d;
      deq_q   <= deq_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    res_q   <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.queue_empty == (count_q == '0)))
    else $error("queue_empty disagrees with entry count");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.dropped) |-> (full && !res_o.found))
    else $error("enqueue dropped while queue not full");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q >= CNT_W'(2) && CNT_W'(idx_q) < count_q))
    else $error("priority walk outside stored entries");
`endif

endmodule

// ----- hw/rtl/trqp_slot_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trqp_slot_ram
// Slot storage for the ready queue: one write port and one read port, read
// data registered, no reset on the contents.
// ----------------------------------------------------------------------------
module trqp_slot_ram #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  trqp_pkg::trqp_entry_t wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output trqp_pkg::trqp_entry_t rdata_o
);
  import trqp_pkg::*;

  trqp_entry_t mem_q [Depth];
  trqp_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
